### hdl/lgs_pkg.sv
`timescale 1ns / 1ps

package lgs_pkg;

    localparam int CAUSE_W   = 3;
    localparam int LIMIT_W   = 7;
    localparam int VALUE_W   = 8;
    localparam int POS_W     = 6;
    localparam int SPAN_W    = VALUE_W + 1;
    localparam int DIV_STEPS = VALUE_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CAUSE_W-1:0] NUM_CAUSES = 3'd6;

    typedef struct packed {
        logic [CAUSE_W-1:0] cause_code;
        logic [LIMIT_W-1:0] limit;
    } t_in_beat;

    typedef struct packed {
        logic [CAUSE_W-1:0] action_code;
        logic [VALUE_W-1:0] grid_point;
        logic [POS_W-1:0]   position;
        logic               final_flag;
        logic               error_flag;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic err_beat;
        logic div_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_err;
        logic single;
        logic div_last;
        logic last;
    } t_stat;

    function automatic logic [VALUE_W-1:0] range_lower(input logic [CAUSE_W-1:0] cause);
        logic [VALUE_W-1:0] v;
        case (cause)
            3'd0: v = 8'd0;
            3'd1: v = 8'd1;
            3'd2: v = 8'd1;
            3'd3: v = 8'd0;
            3'd4: v = 8'd0;
            3'd5: v = 8'd1;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [VALUE_W-1:0] range_upper(input logic [CAUSE_W-1:0] cause);
        logic [VALUE_W-1:0] v;
        case (cause)
            3'd0: v = 8'd100;
            3'd1: v = 8'd4;
            3'd2: v = 8'd10;
            3'd3: v = 8'd100;
            3'd4: v = 8'd255;
            3'd5: v = 8'd200;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

### hdl/lgs_ctrl.sv
`timescale 1ns / 1ps

module lgs_ctrl
    import lgs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_stat.in_err) begin
                        o_cmd.err_beat = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = i_stat.single ? ST_EMIT : ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

### hdl/lgs_datapath.sv
`timescale 1ns / 1ps

module lgs_datapath
    import lgs_pkg::*;
#(
    parameter int MAX_LIMIT = 64
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_req,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output t_out_beat o_result,
    output logic      o_strobe
);

    logic [CAUSE_W-1:0] r_cause;
    logic [VALUE_W-1:0] r_q;
    logic [POS_W-1:0]   r_r;
    logic [POS_W-1:0]   r_den;
    logic [POS_W-1:0]   r_idx;
    logic [VALUE_W-1:0] r_dvd;
    logic [POS_W-1:0]   r_rem;
    logic [STEP_W-1:0]  r_step;
    t_out_beat          r_out;
    logic               r_strobe;

    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    logic [LIMIT_W-1:0] lim_sat;
    logic [SPAN_W-1:0]  avail;
    logic [LIMIT_W-1:0] cnt;
    logic [POS_W:0]     rem_sh;
    logic               q_bit;
    logic [POS_W:0]     acc;
    logic               wrap;
    logic [POS_W-1:0]   half;
    logic               rnd;

    assign lo      = range_lower(i_req.cause_code);
    assign hi      = range_upper(i_req.cause_code);
    assign lim_sat = (i_req.limit > LIMIT_W'(MAX_LIMIT)) ? LIMIT_W'(MAX_LIMIT) : i_req.limit;
    assign avail   = {1'b0, hi} - {1'b0, lo} + SPAN_W'(1);
    assign cnt     = (SPAN_W'(lim_sat) < avail) ? lim_sat : avail[LIMIT_W-1:0];

    assign o_stat.in_err   = (i_req.limit == '0) || (i_req.cause_code >= NUM_CAUSES);
    assign o_stat.single   = (cnt == LIMIT_W'(1));
    assign o_stat.div_last = (r_step == '0);
    assign o_stat.last     = (r_idx == r_den);

    assign rem_sh = {r_rem, r_dvd[VALUE_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_den});

    assign acc  = {1'b0, r_r} + {1'b0, r_rem};
    assign wrap = (acc >= {1'b0, r_den});

    assign half = r_den >> 1;
    assign rnd  = (r_den != '0) &&
                  ((r_r > half) || (!r_den[0] && (r_r == half) && r_q[0]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cause <= i_req.cause_code;
            r_q     <= lo;
            r_r     <= '0;
            r_den   <= POS_W'(cnt - LIMIT_W'(1));
            r_idx   <= '0;
            r_dvd   <= hi - lo;
            r_rem   <= '0;
            r_step  <= STEP_W'(DIV_STEPS - 1);
        end else if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[VALUE_W-2:0], q_bit};
            r_rem  <= q_bit ? POS_W'(rem_sh - {1'b0, r_den}) : rem_sh[POS_W-1:0];
            r_step <= r_step - STEP_W'(1);
        end else if (i_cmd.emit) begin
            r_r   <= wrap ? POS_W'(acc - {1'b0, r_den}) : acc[POS_W-1:0];
            r_q   <= r_q + r_dvd + VALUE_W'(wrap);
            r_idx <= r_idx + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_beat) begin
            r_out.action_code <= '0;
            r_out.grid_point  <= '0;
            r_out.position    <= '0;
            r_out.final_flag  <= 1'b1;
            r_out.error_flag  <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out.action_code <= r_cause;
            r_out.grid_point  <= r_q + VALUE_W'(rnd);
            r_out.position    <= r_idx;
            r_out.final_flag  <= o_stat.last;
            r_out.error_flag  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.err_beat || i_cmd.emit;
        end
    end

    assign o_result = r_out;
    assign o_strobe = r_strobe;

endmodule

### hdl/linear_grid_sampler_top.sv
`timescale 1ns / 1ps

// A run of two or more values first passes through the serial divider, then gives one result per cycle.
// A serial divider sets the step between grid points; a run of one value skips the divider.
// An error request gives one result in the cycle after acceptance and leaves the block idle.
// Results cannot be stalled; each beat shows on o_result for one cycle with o_strobe high.
// Synchronous active-low reset returns the controller to idle and clears the strobe.
module linear_grid_sampler_top
    import lgs_pkg::*;
#(
    parameter int MAX_LIMIT = 64
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_beat  i_req,
    output t_out_beat o_result,
    output logic      o_strobe
);

    t_cmd  cmd;
    t_stat stat;
    logic  req_err;

    lgs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    lgs_datapath #(
        .MAX_LIMIT (MAX_LIMIT)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

    assign req_err = (i_req.limit == '0) || (i_req.cause_code >= NUM_CAUSES);

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && req_err) |=>
            (o_strobe && o_result.error_flag && o_result.final_flag))
        else $error("error request did not give one final error beat");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.final_flag) |-> busy)
        else $error("block idle while a run is still open");

    a_run_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.final_flag) |=>
            (o_strobe && (o_result.position == $past(o_result.position) + POS_W'(1))))
        else $error("run beats not consecutive");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.error_flag) |->
            (o_result.final_flag && (o_result.grid_point == '0) && (o_result.position == '0)))
        else $error("error beat carries data");

endmodule
